[design/cpls_pkg.sv]
// Shared types and constants for the clamped piecewise-linear schedule block.
// Used by every module in the design folder; depends on nothing else.
package cpls_pkg;

	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 5;
	localparam int NPTS     = 3;
	localparam int DIV_BITS = 32;
	localparam int PIPE_LAT = DIV_BITS + 3;

	localparam logic [2:0] REG_POINTS  = 3'd0;
	localparam logic [2:0] REG_SENS_0  = 3'd1;
	localparam logic [2:0] REG_SENS_1  = 3'd2;
	localparam logic [2:0] REG_SENS_2  = 3'd3;
	localparam logic [2:0] REG_THETA_0 = 3'd4;
	localparam logic [2:0] REG_THETA_1 = 3'd5;
	localparam logic [2:0] REG_THETA_2 = 3'd6;

	typedef struct packed {
		logic [1:0]                       n;
		logic [NPTS-1:0][DATA_W-1:0]      sens;
		logic [NPTS-1:0][DATA_W-1:0]      theta;
	} cfg_t;

	typedef struct packed {
		logic              bypass;
		logic              neg;
		logic [DATA_W-1:0] base;
	} side_t;

endpackage

[design/cpls_regs.sv]
// APB-style register file holding the breakpoint schedule.
// Depends on cpls_pkg for the register codes and the cfg_t struct.
module cpls_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cpls_pkg::ADDR_W-1:0]  paddr,
	input  logic [cpls_pkg::DATA_W-1:0]  pwdata,
	output logic [cpls_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output cpls_pkg::cfg_t               cfg
);
	import cpls_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_POINTS:  cfg_q.n        <= pwdata[1:0];
				REG_SENS_0:  cfg_q.sens[0]  <= pwdata;
				REG_SENS_1:  cfg_q.sens[1]  <= pwdata;
				REG_SENS_2:  cfg_q.sens[2]  <= pwdata;
				REG_THETA_0: cfg_q.theta[0] <= pwdata;
				REG_THETA_1: cfg_q.theta[1] <= pwdata;
				REG_THETA_2: cfg_q.theta[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_POINTS:  prdata = {{(DATA_W-2){1'b0}}, cfg_q.n};
			REG_SENS_0:  prdata = cfg_q.sens[0];
			REG_SENS_1:  prdata = cfg_q.sens[1];
			REG_SENS_2:  prdata = cfg_q.sens[2];
			REG_THETA_0: prdata = cfg_q.theta[0];
			REG_THETA_1: prdata = cfg_q.theta[1];
			REG_THETA_2: prdata = cfg_q.theta[2];
			default:     prdata = '0;
		endcase
	end

endmodule

[design/cpls_select.sv]
// First pipeline stage: clamp checks, segment choice and operand setup.
// Depends on cpls_pkg for cfg_t and side_t.
module cpls_select (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [cpls_pkg::DATA_W-1:0] x,
	input  cpls_pkg::cfg_t              cfg,
	output logic                        valid_s1,
	output logic [cpls_pkg::DATA_W-1:0] u_s1,
	output logic [cpls_pkg::DATA_W-1:0] ds_s1,
	output logic [cpls_pkg::DATA_W-1:0] mag_s1,
	output cpls_pkg::side_t             side_s1
);
	import cpls_pkg::*;

	logic signed [DATA_W-1:0] xs, s0, s1, s2, s_last;
	logic [DATA_W-1:0]        t_last, s_lo, s_hi, t_lo, t_hi;
	logic                     in0, seg;
	logic [DATA_W:0]          ds_w, u_w, dt_w, mag_w;
	side_t                    side;

	assign xs = $signed(x);
	assign s0 = $signed(cfg.sens[0]);
	assign s1 = $signed(cfg.sens[1]);
	assign s2 = $signed(cfg.sens[2]);

	always_comb begin
		s_last = (cfg.n == 2'd3) ? s2 : s1;
		t_last = (cfg.n == 2'd3) ? cfg.theta[2] : cfg.theta[1];
		in0    = (xs >= s0) && (xs <= s1);
		seg    = !in0;
		s_lo   = seg ? cfg.sens[1]  : cfg.sens[0];
		s_hi   = seg ? cfg.sens[2]  : cfg.sens[1];
		t_lo   = seg ? cfg.theta[1] : cfg.theta[0];
		t_hi   = seg ? cfg.theta[2] : cfg.theta[1];
		ds_w   = {s_hi[DATA_W-1], s_hi} - {s_lo[DATA_W-1], s_lo};
		u_w    = {x[DATA_W-1], x} - {s_lo[DATA_W-1], s_lo};
		dt_w   = {t_hi[DATA_W-1], t_hi} - {t_lo[DATA_W-1], t_lo};
		mag_w  = dt_w[DATA_W] ? (~dt_w + 1'b1) : dt_w;

		side.bypass = 1'b1;
		side.neg    = dt_w[DATA_W];
		side.base   = t_lo;
		if (cfg.n == 2'd0) begin
			side.base = '0;
		end else if (cfg.n == 2'd1 || xs <= s0) begin
			side.base = cfg.theta[0];
		end else if (xs >= s_last) begin
			side.base = t_last;
		end else if (!in0 && !(cfg.n == 2'd3 && xs >= s1 && xs <= s2)) begin
			side.base = t_last;
		end else if (ds_w == '0) begin
			side.base = t_lo;
		end else begin
			side.bypass = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		u_s1    <= u_w[DATA_W-1:0];
		ds_s1   <= ds_w[DATA_W-1:0];
		mag_s1  <= mag_w[DATA_W-1:0];
		side_s1 <= side;
	end

endmodule

[design/cpls_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on cpls_pkg for widths and side_t; quotient must fit DIV_BITS.
module cpls_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [2*cpls_pkg::DATA_W-1:0] num,
	input  logic [cpls_pkg::DATA_W-1:0]   den,
	input  cpls_pkg::side_t               in_side,
	output logic                          out_valid,
	output logic [cpls_pkg::DIV_BITS-1:0] quo,
	output cpls_pkg::side_t               out_side
);
	import cpls_pkg::*;

	logic [DIV_BITS-1:0]              vld_s;
	logic [DIV_BITS-1:0][DATA_W-1:0]  rem_s;
	logic [DIV_BITS-1:0][DATA_W-1:0]  low_s;
	logic [DIV_BITS-1:0][DATA_W-1:0]  den_s;
	logic [DIV_BITS-1:0][DIV_BITS-1:0] quo_s;
	side_t [DIV_BITS-1:0]             side_s;

	genvar i;
	generate
		for (i = 0; i < DIV_BITS; i++) begin : g_stage
			logic [DATA_W-1:0]   rem_in, low_in, den_in;
			logic [DIV_BITS-1:0] quo_in;
			side_t               side_in;
			logic                vld_in, ge;
			logic [DATA_W:0]     trial, diff;

			if (i == 0) begin : g_first
				assign vld_in  = in_valid;
				assign rem_in  = num[2*DATA_W-1:DATA_W];
				assign low_in  = num[DATA_W-1:0];
				assign den_in  = den;
				assign quo_in  = '0;
				assign side_in = in_side;
			end else begin : g_next
				assign vld_in  = vld_s[i-1];
				assign rem_in  = rem_s[i-1];
				assign low_in  = low_s[i-1];
				assign den_in  = den_s[i-1];
				assign quo_in  = quo_s[i-1];
				assign side_in = side_s[i-1];
			end

			assign trial = {rem_in, low_in[DATA_W-1]};
			assign diff  = trial - {1'b0, den_in};
			assign ge    = !diff[DATA_W];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else begin
					vld_s[i] <= vld_in;
				end
			end

			always_ff @(posedge clk) begin
				rem_s[i]  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
				low_s[i]  <= {low_in[DATA_W-2:0], 1'b0};
				den_s[i]  <= den_in;
				quo_s[i]  <= {quo_in[DIV_BITS-2:0], ge};
				side_s[i] <= side_in;
			end
		end
	endgenerate

	assign out_valid = vld_s[DIV_BITS-1];
	assign quo       = quo_s[DIV_BITS-1];
	assign out_side  = side_s[DIV_BITS-1];

endmodule

[design/clamped_piecewise_linear_schedule.sv]
// Top level of the clamped piecewise-linear schedule lookup.
// Depends on cpls_pkg, cpls_regs, cpls_select and cpls_div.
//
// Usage:
//   Configuration: APB-style port, registers at byte address 4*i in the order
//   points_in_use, sens_point_0..2, theta_point_0..2. pready is always high.
//   Write the schedule only while no lookup is in flight.
//   Input: a beat is taken at each rising edge with start high and busy low.
//   busy stays low, so a new sensor_value may enter every cycle.
//   Output: done is high for one cycle with theta_value; the receiver takes
//   every result and cannot stall.
//   Pipeline: select stage, multiply stage, 32 divider stages, output stage.
//   Throughput: one beat per cycle, set by the one-bit-per-stage divider.
//   Reset: clears the schedule registers to zero and drops every beat in flight.
module clamped_piecewise_linear_schedule (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cpls_pkg::ADDR_W-1:0]        paddr,
	input  logic [cpls_pkg::DATA_W-1:0]        pwdata,
	output logic [cpls_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [cpls_pkg::DATA_W-1:0] sensor_value,
	output logic                               done,
	output logic signed [cpls_pkg::DATA_W-1:0] theta_value
);
	import cpls_pkg::*;

	cfg_t                cfg;
	logic                valid_s1, valid_s2, dv_valid, done_q;
	logic [DATA_W-1:0]   u_s1, ds_s1, mag_s1, ds_s2;
	logic [2*DATA_W-1:0] prod_s2;
	side_t               side_s1, side_s2, dv_side;
	logic [DIV_BITS-1:0] dv_quo;
	logic [DATA_W-1:0]   theta_q;

	assign busy = 1'b0;

	cpls_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpls_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.x        (sensor_value),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.u_s1     (u_s1),
		.ds_s1    (ds_s1),
		.mag_s1   (mag_s1),
		.side_s1  (side_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= {{DATA_W{1'b0}}, u_s1} * {{DATA_W{1'b0}}, mag_s1};
		ds_s2   <= ds_s1;
		side_s2 <= side_s1;
	end

	cpls_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.num       (prod_s2),
		.den       (ds_s2),
		.in_side   (side_s2),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.out_side  (dv_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_side.bypass) begin
			theta_q <= dv_side.base;
		end else if (dv_side.neg) begin
			theta_q <= dv_side.base - dv_quo;
		end else begin
			theta_q <= dv_side.base + dv_quo;
		end
	end

	assign done        = done_q;
	assign theta_value = $signed(theta_q);

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_LAT done)
		else $error("accepted beat did not produce a result on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without a matching input beat");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cfg.n == 2'd0 |-> ##PIPE_LAT (done && theta_value == '0))
		else $error("empty schedule did not return zero");
`endif

endmodule

[sim/testbench.sv]
// Self-checking bench for clamped_piecewise_linear_schedule: APB schedule writes,
// a gapped stream of sensor beats, and an in-order predictor checking theta_value.
// Depends on cpls_pkg and the design sources.
module testbench;
	import cpls_pkg::*;

	localparam logic [2:0] REG_SPARE      = 3'd7;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         RANDOM_PHASES  = 8;
	localparam int         PHASE_BEATS    = 120;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     psel         = 1'b0;
	logic                     penable      = 1'b0;
	logic                     pwrite       = 1'b0;
	logic [ADDR_W-1:0]        paddr        = '0;
	logic [DATA_W-1:0]        pwdata       = '0;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;
	logic                     start        = 1'b0;
	logic                     busy;
	logic signed [DATA_W-1:0] sensor_value = '0;
	logic                     done;
	logic signed [DATA_W-1:0] theta_value;

	logic [1:0]               pts_used;
	logic signed [DATA_W-1:0] sens_pt [NPTS];
	logic signed [DATA_W-1:0] theta_pt [NPTS];

	logic signed [DATA_W-1:0] pending_sensor [$];
	logic signed [DATA_W-1:0] expected_theta [$];
	logic signed [DATA_W-1:0] next_theta;
	int                       issued_count   = 0;
	int                       accepted_count = 0;
	int                       mismatches     = 0;
	int                       gap_left       = 0;
	int                       stall_cycles   = 0;
	bit                       dense_phase    = 1'b0;

	clamped_piecewise_linear_schedule u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.sensor_value (sensor_value),
		.done         (done),
		.theta_value  (theta_value)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic signed [DATA_W-1:0] schedule_value(
		input logic signed [DATA_W-1:0] x
	);
		int                n = pts_used;
		longint            ds;
		longint            dt;
		longint unsigned   ds_u;
		longint unsigned   u;
		longint unsigned   mag;
		longint unsigned   q;
		if (n == 0)
			return '0;
		if (n == 1)
			return theta_pt[0];
		if (x <= sens_pt[0])
			return theta_pt[0];
		if (x >= sens_pt[n-1])
			return theta_pt[n-1];
		for (int k = 0; k + 1 < n; k++) begin
			if (x >= sens_pt[k] && x <= sens_pt[k+1]) begin
				ds = longint'(sens_pt[k+1]) - longint'(sens_pt[k]);
				if (ds == 0)
					return theta_pt[k];
				dt   = longint'(theta_pt[k+1]) - longint'(theta_pt[k]);
				u    = longint'(x) - longint'(sens_pt[k]);
				mag  = (dt < 0) ? -dt : dt;
				ds_u = ds;
				q    = (mag * u) / ds_u;
				if (dt < 0)
					return 32'(longint'(theta_pt[k]) - longint'(q));
				return 32'(longint'(theta_pt[k]) + longint'(q));
			end
		end
		return theta_pt[n-1];
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx) inside
			REG_POINTS:                          pts_used = value[1:0];
			REG_SENS_0, REG_SENS_1, REG_SENS_2:  sens_pt[2'(idx - REG_SENS_0)] = value;
			REG_THETA_0, REG_THETA_1, REG_THETA_2:
				theta_pt[2'(idx - REG_THETA_0)] = value;
			default: ;
		endcase
	endtask

	task automatic load_schedule(
		input logic [1:0]        n,
		input logic [DATA_W-1:0] s0, s1, s2,
		input logic [DATA_W-1:0] t0, t1, t2
	);
		write_reg(REG_SENS_0, s0);
		write_reg(REG_SENS_1, s1);
		write_reg(REG_SENS_2, s2);
		write_reg(REG_THETA_0, t0);
		write_reg(REG_THETA_1, t1);
		write_reg(REG_THETA_2, t2);
		write_reg(REG_POINTS, {30'($urandom), n});
	endtask

	task automatic queue_reading(input logic signed [DATA_W-1:0] x);
		pending_sensor.push_back(x);
		issued_count++;
	endtask

	task automatic drain();
		@(posedge clk);
		while (accepted_count != issued_count || expected_theta.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(
		input string             what,
		input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got
	);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected %h got %h", what, want, got);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start    <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				expected_theta.push_back(schedule_value(sensor_value));
				accepted_count++;
			end
			if (start && busy) begin
				// hold the beat
			end else if (gap_left != 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_sensor.size() != 0) begin
				start        <= 1'b1;
				sensor_value <= pending_sensor.pop_front();
				if (dense_phase || $urandom_range(0, 9) < 6)
					gap_left <= 0;
				else if ($urandom_range(0, 9) < 8)
					gap_left <= $urandom_range(1, 3);
				else
					gap_left <= $urandom_range(5, 40);
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_theta.size() == 0) begin
				report_mismatch("unexpected theta_value", 'x, theta_value);
			end else begin
				next_theta = expected_theta.pop_front();
				if (theta_value !== next_theta)
					report_mismatch("theta_value mismatch", next_theta, theta_value);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable && pwrite && pready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int                       n;
		int                       mode;
		int                       k;
		int                       pick;
		longint                   lo;
		longint                   hi;
		longint                   span;
		logic signed [DATA_W-1:0] s [NPTS];
		logic signed [DATA_W-1:0] t [NPTS];
		logic signed [DATA_W-1:0] swap;

		pts_used = '0;
		for (k = 0; k < NPTS; k++) begin
			sens_pt[k]  = '0;
			theta_pt[k] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty schedule after reset
		queue_reading(32'h8000_0000);
		queue_reading(32'h7FFF_FFFF);
		queue_reading(32'h0000_0000);
		queue_reading(32'hFFFF_FFFF);
		drain();

		// single point, count taken from the low bits only
		write_reg(REG_POINTS, 32'hFFFF_FFFD);
		write_reg(REG_THETA_0, 32'h8000_0000);
		queue_reading(32'h1234_5678);
		queue_reading(32'h7FFF_FFFF);
		drain();

		load_schedule(2'd3, 32'hFFFF_0000, 32'h0000_0000, 32'h0003_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345);
		queue_reading(32'h8000_0000);
		queue_reading(32'hFFFF_0000);
		queue_reading(32'hFFFF_8000);
		queue_reading(32'h0000_0000);
		queue_reading(32'h0001_8000);
		queue_reading(32'h0002_FFFF);
		queue_reading(32'h0003_0000);
		queue_reading(32'h7FFF_FFFF);
		drain();

		// full-width segments
		load_schedule(2'd3, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_reading(32'h8000_0001);
		queue_reading(32'hC000_0000);
		queue_reading(32'h0000_0001);
		queue_reading(32'h7FFF_FFFE);
		drain();

		// third pair out of use, spare address ignored
		load_schedule(2'd2, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000,
			32'h0000_0064, 32'h0000_00C8, 32'h5555_5555);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		queue_reading(32'h0000_8000);
		queue_reading(32'h0001_0000);
		queue_reading(32'h0002_0000);
		drain();

		// zero-width first segment, descending tail
		load_schedule(2'd3, 32'h0005_0000, 32'h0005_0000, 32'h0001_0000,
			32'hAAAA_AAAA, 32'h1111_1111, 32'h2222_2222);
		queue_reading(32'h0003_0000);
		queue_reading(32'h0005_0000);
		queue_reading(32'h0006_0000);
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			n    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 3);
			mode = $urandom_range(0, 3);
			for (k = 0; k < NPTS; k++) begin
				s[k] = mode[0] ? $urandom_range(0, 32'h7FFFF) - 32'h40000 : $urandom;
				if ($urandom_range(0, 3) == 0)
					t[k] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				else
					t[k] = $urandom;
			end
			if (mode != 3) begin
				if (s[0] > s[1]) begin swap = s[0]; s[0] = s[1]; s[1] = swap; end
				if (s[1] > s[2]) begin swap = s[1]; s[1] = s[2]; s[2] = swap; end
				if (s[0] > s[1]) begin swap = s[0]; s[0] = s[1]; s[1] = swap; end
			end
			load_schedule(2'(n), s[0], s[1], s[2], t[0], t[1], t[2]);
			dense_phase = ($urandom_range(0, 3) == 0);

			for (int i = 0; i < PHASE_BEATS; i++) begin
				pick = $urandom_range(0, 9);
				k    = $urandom_range(0, NPTS - 1);
				if (pick < 6 && pts_used >= 2) begin
					k  = $urandom_range(0, pts_used - 2);
					lo = sens_pt[k];
					hi = sens_pt[k+1];
					if (lo > hi) begin
						span = lo;
						lo   = hi;
						hi   = span;
					end
					span = hi - lo;
					queue_reading(32'(lo + longint'({$urandom, $urandom} % 64'(span + 1))));
				end else if (pick < 8) begin
					queue_reading(sens_pt[k] + 32'(int'($urandom_range(0, 2)) - 1));
				end else begin
					queue_reading($urandom);
				end
			end
			drain();
			dense_phase = 1'b0;
		end

		repeat (PIPE_LAT + 8) @(posedge clk);
		mismatches += expected_theta.size();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[clamped_piecewise_linear_schedule.f]
design/cpls_pkg.sv
design/cpls_regs.sv
design/cpls_select.sv
design/cpls_div.sv
design/clamped_piecewise_linear_schedule.sv
sim/testbench.sv
